// ----- design/slir_pkg.sv -----
// Shared types and constants for the sorted list store.
`default_nettype none

package slir_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 5;
	localparam int GROUP_W      = 32;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic                      mode;
		logic signed [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] count;
	} rsp_item_t;

	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic rem_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/sorted_list_insert_remove.sv -----
// Sorted list store: a chain of compare-and-shift cells holding ascending keys.
// The result is registered after the compare, match reduce and update steps; a
// stalled result holds the update step until it is taken.
// A new item is taken only once the previous item has finished its update step.
// Reset: arst_n clears the entry count, sequencer and result valid; cell contents are not cleared.
`default_nettype none

module sorted_list_insert_remove #(
	parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  slir_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output slir_pkg::rsp_item_t  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NG = (CAPACITY + slir_pkg::GROUP_W - 1) / slir_pkg::GROUP_W;

	// Sequencer phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_CMP   = 2'd1;
	localparam logic [1:0] PH_RED   = 2'd2;
	localparam logic [1:0] PH_APPLY = 2'd3;

	logic [1:0]                          phase_q;
	logic                                mode_q;
	logic signed [slir_pkg::VALUE_W-1:0] key_q;
	logic [CW-1:0]                       cnt_q;
	logic                                rsp_valid_q;
	slir_pkg::rsp_item_t                 rsp_q;

	logic signed [slir_pkg::VALUE_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]                 cell_lt;
	logic [CAPACITY-1:0]                 cell_hit;
	logic [NG-1:0]                       grp;

	logic                 req_take;
	logic                 apply_go;
	logic                 not_full;
	logic                 found;
	logic                 op_ok;
	logic [CW-1:0]        cnt_next;
	slir_pkg::cell_ctrl_t ctrl;

	// Take a new item only when the sequencer is idle.
	assign req_stall = (phase_q != PH_IDLE);
	assign req_take  = req_valid && !req_stall;

	// Update only when the result slot is free or being drained.
	assign apply_go = (phase_q == PH_APPLY) && (!rsp_valid_q || !rsp_stall);

	assign not_full = cnt_q < CW'(CAPACITY);
	assign found    = |grp;

	always_comb begin
		op_ok    = 1'b0;
		cnt_next = cnt_q;
		case (mode_q)
			slir_pkg::MODE_INSERT: begin
				op_ok = not_full;
				if (not_full) begin
					cnt_next = cnt_q + CW'(1);
				end
			end
			slir_pkg::MODE_REMOVE: begin
				op_ok = found;
				if (found) begin
					cnt_next = cnt_q - CW'(1);
				end
			end
			default: begin
				op_ok    = 1'b0;
				cnt_next = cnt_q;
			end
		endcase
	end

	assign ctrl.cmp_en = (phase_q == PH_CMP);
	assign ctrl.ins_en = apply_go && (mode_q == slir_pkg::MODE_INSERT) && not_full;
	assign ctrl.rem_en = apply_go && (mode_q == slir_pkg::MODE_REMOVE) && found;

	// Advance the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (req_take) begin
						phase_q <= PH_CMP;
					end
				end
				PH_CMP:   phase_q <= PH_RED;
				PH_RED:   phase_q <= PH_APPLY;
				PH_APPLY: begin
					if (apply_go) begin
						phase_q <= PH_IDLE;
						cnt_q   <= cnt_next;
					end
				end
				default:  phase_q <= PH_IDLE;
			endcase
		end
	end

	// Hold the accepted item for the whole sequence.
	always_ff @(posedge clk) begin
		if (req_take) begin
			mode_q <= req.mode;
			key_q  <= req.value;
		end
	end

	// Result register: load on update, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			rsp_q.ok    <= op_ok;
			rsp_q.count <= slir_pkg::COUNT_W'(cnt_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Cell chain: cell 0 takes the key on insert, the last cell refills from itself on remove.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [slir_pkg::VALUE_W-1:0] left_data;
		logic                                left_lt;
		logic signed [slir_pkg::VALUE_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = key_q;
			assign left_lt   = 1'b1;
		end else begin : g_mid
			assign left_data = cell_data[i-1];
			assign left_lt   = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_inner
			assign right_data = cell_data[i+1];
		end

		slir_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (key_q),
			.cnt        (cnt_q),
			.left_data  (left_data),
			.left_lt    (left_lt),
			.right_data (right_data),
			.data       (cell_data[i]),
			.lt         (cell_lt[i]),
			.hit        (cell_hit[i])
		);
	end

	slir_hit_reduce #(
		.CAPACITY (CAPACITY),
		.NG       (NG)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.hit    (cell_hit),
		.grp    (grp)
	);

endmodule

`default_nettype wire

// ----- design/slir_cell.sv -----
// One storage cell of the sorted chain: compare against the key, shift on update.
`default_nettype none

module slir_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  slir_pkg::cell_ctrl_t                 ctrl,
	input  wire signed [slir_pkg::VALUE_W-1:0]   key,
	input  wire        [CW-1:0]                  cnt,
	input  wire signed [slir_pkg::VALUE_W-1:0]   left_data,
	input  wire                                  left_lt,
	input  wire signed [slir_pkg::VALUE_W-1:0]   right_data,
	output logic signed [slir_pkg::VALUE_W-1:0]  data,
	output logic                                 lt,
	output logic                                 hit
);

	logic signed [slir_pkg::VALUE_W-1:0] data_q;
	logic                                lt_q;
	logic                                hit_q;
	logic                                occ;

	assign occ = CW'(IDX) < cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q  <= 1'b0;
			hit_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			lt_q  <= occ && (data_q < key);
			hit_q <= occ && (data_q == key);
		end
	end

	// Cells ahead of the insert/remove point keep their entry.
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && !lt_q) begin
			data_q <= left_lt ? key : left_data;
		end else if (ctrl.rem_en && !lt_q) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	assign lt   = lt_q;
	assign hit  = hit_q;

endmodule

`default_nettype wire

// ----- design/slir_hit_reduce.sv -----
// Registered group OR of the per-cell match flags.
`default_nettype none

module slir_hit_reduce #(
	parameter int CAPACITY = slir_pkg::CAPACITY_DEF,
	parameter int NG       = 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [CAPACITY-1:0] hit,
	output logic [NG-1:0]       grp
);

	localparam int PAD_W = NG * slir_pkg::GROUP_W;

	logic [PAD_W-1:0] hit_pad;
	logic [NG-1:0]    grp_q;

	assign hit_pad = PAD_W'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else begin
			for (int g = 0; g < NG; g++) begin
				grp_q[g] <= |hit_pad[g*slir_pkg::GROUP_W +: slir_pkg::GROUP_W];
			end
		end
	end

	assign grp = grp_q;

endmodule

`default_nettype wire

// ----- verif/sorted_list_insert_remove_test.sv -----
// Testbench for the sorted list store: random and directed insert/remove items against a predictor.
`timescale 1ns / 100ps

module sorted_list_insert_remove_test;

	localparam int LIST_DEPTH = slir_pkg::CAPACITY_DEF;
	localparam int HOLD_LEN   = 60;        // long receiver hold-off, in cycles
	localparam int IDLE_PCT   = 11;        // chance per cycle that a side idles
	localparam int RANDOM_OPS = 480;
	localparam logic signed [slir_pkg::VALUE_W-1:0] KEY_MIN =
		{1'b1, {(slir_pkg::VALUE_W-1){1'b0}}};
	localparam logic signed [slir_pkg::VALUE_W-1:0] KEY_MAX =
		{1'b0, {(slir_pkg::VALUE_W-1){1'b1}}};

	// One pending item plus the traffic hints that travel with it.
	typedef struct {
		slir_pkg::req_item_t op;
		bit        wait_empty;  // hold the item until every result is back
		bit        quiet;       // no idling on either side while these flow
		bit        hold_rx;     // start the long receiver hold-off on acceptance
	} pending_op_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	slir_pkg::req_item_t req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	slir_pkg::rsp_item_t rsp;

	pending_op_t         pending_ops[$];
	slir_pkg::rsp_item_t expected_rsps[$];
	pending_op_t         offered_op;
	bit                  req_taken = 1'b0;
	bit                  sender_quiet = 1'b0;
	bit                  rx_quiet = 1'b0;
	bit                  hold_start = 1'b0;
	int                  hold_left = 0;
	int                  errors = 0;

	// Predictor state: the ascending key list and its fill level.
	logic signed [slir_pkg::VALUE_W-1:0] list_keys [LIST_DEPTH];
	int                                  list_count = 0;

	// Keys the stimulus believes are stored, so removes mostly hit.
	logic signed [slir_pkg::VALUE_W-1:0] live_keys[$];

	sorted_list_insert_remove dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// Apply one item to the predicted list and return the result it yields.
	function automatic slir_pkg::rsp_item_t apply_list_op(slir_pkg::req_item_t op);
		slir_pkg::rsp_item_t                 res;
		int                                  pos;
		logic signed [slir_pkg::VALUE_W-1:0] key;
		key = op.value;
		res.ok = 1'b0;
		pos = 0;
		while (pos < list_count && list_keys[pos] < key)
			pos++;
		if (op.mode == slir_pkg::MODE_INSERT) begin
			// A full list refuses the key; otherwise land in front of equal keys.
			if (list_count < LIST_DEPTH) begin
				for (int j = list_count; j > pos; j--)
					list_keys[j] = list_keys[j - 1];
				list_keys[pos] = key;
				list_count++;
				res.ok = 1'b1;
			end
		end else begin
			// Drop the first equal key; an empty list or absent key leaves it alone.
			if (pos < list_count && list_keys[pos] == key) begin
				for (int j = pos; j + 1 < list_count; j++)
					list_keys[j] = list_keys[j + 1];
				list_count--;
				res.ok = 1'b1;
			end
		end
		res.count = list_count[slir_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// Favor small clustered keys so duplicates and hits are common.
	function automatic logic signed [slir_pkg::VALUE_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return $signed($urandom_range(8)) - 4;
		else if (roll < 70)
			return $urandom;
		else if (roll < 85)
			case ($urandom_range(3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return 0;
				default: return -1;
			endcase
		else if (roll < 93)
			return KEY_MIN + $urandom_range(3);
		else
			return KEY_MAX - $urandom_range(3);
	endfunction

	task automatic queue_op(logic mode, logic signed [slir_pkg::VALUE_W-1:0] key,
			bit wait_empty, bit quiet, bit hold_rx);
		pending_op_t p;
		p.op.mode = mode;
		p.op.value = key;
		p.wait_empty = wait_empty;
		p.quiet = quiet;
		p.hold_rx = hold_rx;
		pending_ops.push_back(p);
	endtask

	// Sample the request handshake; predict each accepted item right away.
	always @(posedge clk) begin : accept_req
		req_taken = arst_n && req_valid && !req_stall;
		if (req_taken) begin
			expected_rsps.push_back(apply_list_op(req));
			rx_quiet = offered_op.quiet;
			if (offered_op.hold_rx)
				hold_start = 1'b1;
		end
	end

	// Request driver: advance on acceptance, idle at random, pause where asked.
	always @(negedge clk) begin : drive_req
		logic                nxt_valid;
		slir_pkg::req_item_t nxt_req;
		nxt_valid = req_valid;
		nxt_req = req;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else begin
			if (req_taken)
				nxt_valid = 1'b0;
			if (!nxt_valid && pending_ops.size() > 0) begin
				// Hold a pausing item until the block has handed back everything.
				if (pending_ops[0].wait_empty && expected_rsps.size() != 0) begin
					nxt_valid = 1'b0;
				end else if (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
					nxt_valid = 1'b0;
				end else begin
					offered_op = pending_ops.pop_front();
					sender_quiet = offered_op.quiet;
					nxt_valid = 1'b1;
					nxt_req = offered_op.op;
				end
			end
		end
		req_valid <= nxt_valid;
		req <= nxt_req;
	end

	// Result receiver: random stalls, plus one long hold-off counted here.
	always @(negedge clk) begin : drive_rsp_stall
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (hold_start) begin
			hold_start = 1'b0;
			hold_left = HOLD_LEN - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !rx_quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Monitor: compare every accepted result with the oldest prediction.
	always @(posedge clk) begin : check_rsp
		slir_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result: ok=%0d count=%0d", rsp.ok, rsp.count);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.ok !== want.ok) begin
					$error("ok: expected %0d, actual %0d", want.ok, rsp.ok);
					errors++;
				end
				if (rsp.count !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count, rsp.count);
					errors++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int                                  roll;
		int                                  idx;
		bit                                  fill_phase;
		logic                                mode;
		logic signed [slir_pkg::VALUE_W-1:0] key;

		// Directed: remove from an empty list, extremes, duplicates, absent key.
		queue_op(slir_pkg::MODE_REMOVE, 0, 0, 0, 0);
		queue_op(slir_pkg::MODE_INSERT, KEY_MIN, 0, 0, 0);
		queue_op(slir_pkg::MODE_INSERT, KEY_MAX, 0, 0, 0);
		queue_op(slir_pkg::MODE_INSERT, 0, 0, 0, 0);
		queue_op(slir_pkg::MODE_INSERT, -1, 0, 0, 0);
		queue_op(slir_pkg::MODE_INSERT, 0, 0, 0, 0);
		queue_op(slir_pkg::MODE_REMOVE, 5, 0, 0, 0);
		queue_op(slir_pkg::MODE_REMOVE, 0, 0, 0, 0);
		queue_op(slir_pkg::MODE_REMOVE, KEY_MIN, 0, 0, 0);
		queue_op(slir_pkg::MODE_REMOVE, KEY_MAX, 0, 0, 0);
		live_keys.push_back(0);
		live_keys.push_back(-1);
		// Fill to capacity, with some equal keys, then insert into a full list.
		for (int i = 0; i < LIST_DEPTH - 2; i++) begin
			key = (i % 4 == 0) ? 7 : (i * 3 - 20);
			queue_op(slir_pkg::MODE_INSERT, key, 0, 0, 0);
			live_keys.push_back(key);
		end
		queue_op(slir_pkg::MODE_INSERT, 3, 0, 0, 0);

		// Random: alternate drain-leaning and fill-leaning phases of well-formed
		// traffic, with a little noise mixed in.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			fill_phase = ((n / 40) % 2) == 1;
			roll = $urandom_range(99);
			if (roll < 5) begin
				mode = ($urandom_range(1) == 0) ? slir_pkg::MODE_INSERT
					: slir_pkg::MODE_REMOVE;
				key = $urandom;
			end else begin
				mode = (fill_phase ? roll < 75 : roll < 25) ? slir_pkg::MODE_INSERT
					: slir_pkg::MODE_REMOVE;
				if (mode == slir_pkg::MODE_REMOVE && live_keys.size() > 0
						&& $urandom_range(99) < 80) begin
					idx = $urandom_range(live_keys.size() - 1);
					key = live_keys[idx];
					live_keys.delete(idx);
				end else begin
					key = pick_key();
				end
			end
			if (mode == slir_pkg::MODE_INSERT && live_keys.size() < LIST_DEPTH)
				live_keys.push_back(key);
			queue_op(mode, key, n == 50 || n == 350, n >= 200 && n < 300, n == 100);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last item to go in and its result to come back.
		while (pending_ops.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule
